@@ hdl/lpsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsp_pkg
// Shared types, constants and the signature table of the point stream parser.
// ----------------------------------------------------------------------------
package lpsp_pkg;

  localparam int HEADER_SKIP_BYTES  = 78;
  localparam int POINTS_PER_PACKAGE = 96;
  localparam int AUX_SKIP_BYTES     = 24;

  localparam int SIG_LEN      = 10;
  localparam int FRAME_FIELD  = 8;
  localparam int PKG_HEAD_LEN = 10;
  localparam int PKG_TS_LEN   = 8;
  localparam int WORD_LEN     = 4;
  localparam int PT_TAIL_LEN  = 2;

  localparam logic [63:0] HDR_END = 64'(SIG_LEN + HEADER_SKIP_BYTES);

  localparam logic [7:0] TYPE_POINTS = 8'd2;
  localparam logic [7:0] TYPE_AUX    = 8'd6;

  localparam logic [1:0] KIND_POINT    = 2'd0;
  localparam logic [1:0] KIND_SIG_ERR  = 2'd1;
  localparam logic [1:0] KIND_TYPE_ERR = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        points_seen;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h6c;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h76;
      4'd3:    c = 8'h6f;
      4'd4:    c = 8'h78;
      4'd5:    c = 8'h5f;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h65;
      4'd8:    c = 8'h63;
      4'd9:    c = 8'h68;
      default: c = 8'h6c;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/lpsp_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsp_parse
// Byte-wise parse state machine; updates state on each accepted byte and
// raises push with a result when a point completes or an error is found.
// ----------------------------------------------------------------------------
module lpsp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  output logic              push,
  output lpsp_pkg::result_t res
);

  localparam logic [3:0] PH_SIG     = 4'd0;
  localparam logic [3:0] PH_HDR     = 4'd1;
  localparam logic [3:0] PH_FR_PRE  = 4'd2;
  localparam logic [3:0] PH_FR_OFF  = 4'd3;
  localparam logic [3:0] PH_FR_IDX  = 4'd4;
  localparam logic [3:0] PH_PK_HEAD = 4'd5;
  localparam logic [3:0] PH_PK_TYPE = 4'd6;
  localparam logic [3:0] PH_PK_TS   = 4'd7;
  localparam logic [3:0] PH_PT_X    = 4'd8;
  localparam logic [3:0] PH_PT_Y    = 4'd9;
  localparam logic [3:0] PH_PT_Z    = 4'd10;
  localparam logic [3:0] PH_PT_TAIL = 4'd11;
  localparam logic [3:0] PH_AUX     = 4'd12;

  logic [3:0]  phase, phase_next;
  logic [63:0] pos, pos_next;
  logic [6:0]  fcnt, fcnt_next, fcnt_inc;
  logic [63:0] nfo, nfo_next, nfo_lane;
  logic [7:0]  ptype, ptype_next;
  logic [6:0]  pidx, pidx_next, pidx_inc;
  logic [31:0] word, word_next, word_lane, word_new;
  logic [31:0] held_x, held_x_next;
  logic [31:0] held_y, held_y_next;
  logic [31:0] total, total_next;
  logic        halted, halted_next;
  logic        more_pkgs;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      word_lane[i*8 +: 8] = (fcnt[1:0] == 2'(i)) ? data_byte : 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      nfo_lane[i*8 +: 8] = (fcnt[2:0] == 3'(i)) ? data_byte : 8'h00;
    end
  end

  assign fcnt_inc  = fcnt + 7'd1;
  assign pidx_inc  = pidx + 7'd1;
  assign word_new  = word | word_lane;
  assign pos_next  = halted ? pos : pos + 64'd1;
  assign more_pkgs = pos_next < nfo;

  always_comb begin
    phase_next  = phase;
    fcnt_next   = fcnt;
    nfo_next    = nfo;
    ptype_next  = ptype;
    pidx_next   = pidx;
    word_next   = word;
    held_x_next = held_x;
    held_y_next = held_y;
    total_next  = total;
    halted_next = halted;
    push        = 1'b0;
    res         = '{kind: lpsp_pkg::KIND_POINT, coord_x: '0, coord_y: '0,
                    coord_z: '0, points_seen: total};

    if (!halted) begin
      unique case (phase)
        PH_SIG: begin
          if (data_byte != lpsp_pkg::sig_byte(fcnt[3:0])) begin
            halted_next = 1'b1;
            push        = 1'b1;
            res.kind    = lpsp_pkg::KIND_SIG_ERR;
          end else if (fcnt_inc >= 7'(lpsp_pkg::SIG_LEN)) begin
            phase_next = (lpsp_pkg::HEADER_SKIP_BYTES == 0) ? PH_FR_PRE : PH_HDR;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_HDR: begin
          if (pos_next >= lpsp_pkg::HDR_END) begin
            phase_next = PH_FR_PRE;
            fcnt_next  = '0;
          end
        end
        PH_FR_PRE: begin
          if (fcnt_inc >= 7'(lpsp_pkg::FRAME_FIELD)) begin
            phase_next = PH_FR_OFF;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_FR_OFF: begin
          nfo_next = ((fcnt == 7'd0) ? 64'd0 : nfo) | nfo_lane;
          if (fcnt_inc >= 7'(lpsp_pkg::FRAME_FIELD)) begin
            phase_next = PH_FR_IDX;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_FR_IDX: begin
          if (fcnt_inc >= 7'(lpsp_pkg::FRAME_FIELD)) begin
            phase_next = more_pkgs ? PH_PK_HEAD : PH_FR_PRE;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_PK_HEAD: begin
          if (fcnt_inc >= 7'(lpsp_pkg::PKG_HEAD_LEN)) begin
            phase_next = PH_PK_TYPE;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_PK_TYPE: begin
          ptype_next = data_byte;
          if (data_byte != lpsp_pkg::TYPE_POINTS && data_byte != lpsp_pkg::TYPE_AUX) begin
            halted_next = 1'b1;
            push        = 1'b1;
            res.kind    = lpsp_pkg::KIND_TYPE_ERR;
          end else begin
            phase_next = PH_PK_TS;
            fcnt_next  = '0;
          end
        end
        PH_PK_TS: begin
          if (fcnt_inc >= 7'(lpsp_pkg::PKG_TS_LEN)) begin
            fcnt_next = '0;
            if (ptype == lpsp_pkg::TYPE_POINTS) begin
              pidx_next  = '0;
              word_next  = '0;
              phase_next = PH_PT_X;
            end else begin
              phase_next = PH_AUX;
            end
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_PT_X: begin
          if (fcnt_inc >= 7'(lpsp_pkg::WORD_LEN)) begin
            held_x_next = word_new;
            word_next   = '0;
            phase_next  = PH_PT_Y;
            fcnt_next   = '0;
          end else begin
            word_next = word_new;
            fcnt_next = fcnt_inc;
          end
        end
        PH_PT_Y: begin
          if (fcnt_inc >= 7'(lpsp_pkg::WORD_LEN)) begin
            held_y_next = word_new;
            word_next   = '0;
            phase_next  = PH_PT_Z;
            fcnt_next   = '0;
          end else begin
            word_next = word_new;
            fcnt_next = fcnt_inc;
          end
        end
        PH_PT_Z: begin
          if (fcnt_inc >= 7'(lpsp_pkg::WORD_LEN)) begin
            word_next       = '0;
            total_next      = total + 32'd1;
            phase_next      = PH_PT_TAIL;
            fcnt_next       = '0;
            push            = 1'b1;
            res.coord_x     = held_x;
            res.coord_y     = held_y;
            res.coord_z     = word_new;
            res.points_seen = total + 32'd1;
          end else begin
            word_next = word_new;
            fcnt_next = fcnt_inc;
          end
        end
        PH_PT_TAIL: begin
          if (fcnt_inc >= 7'(lpsp_pkg::PT_TAIL_LEN)) begin
            fcnt_next = '0;
            if (pidx_inc >= 7'(lpsp_pkg::POINTS_PER_PACKAGE)) begin
              pidx_next  = '0;
              phase_next = more_pkgs ? PH_PK_HEAD : PH_FR_PRE;
            end else begin
              pidx_next  = pidx_inc;
              phase_next = PH_PT_X;
            end
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        PH_AUX: begin
          if (fcnt_inc >= 7'(lpsp_pkg::AUX_SKIP_BYTES)) begin
            phase_next = more_pkgs ? PH_PK_HEAD : PH_FR_PRE;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        default: begin
          phase_next = PH_SIG;
          fcnt_next  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SIG;
      pos    <= '0;
      fcnt   <= '0;
      nfo    <= '0;
      ptype  <= '0;
      pidx   <= '0;
      word   <= '0;
      held_x <= '0;
      held_y <= '0;
      total  <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      pos    <= pos_next;
      fcnt   <= fcnt_next;
      nfo    <= nfo_next;
      ptype  <= ptype_next;
      pidx   <= pidx_next;
      word   <= word_next;
      held_x <= held_x_next;
      held_y <= held_y_next;
      total  <= total_next;
      halted <= halted_next;
    end
  end

endmodule

@@ hdl/lpsp_obuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsp_obuf
// Result register with a skid entry; ready upstream depends only on state.
// ----------------------------------------------------------------------------
module lpsp_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpsp_pkg::result_t push_res,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output lpsp_pkg::result_t out_res
);

  logic              skid_valid;
  lpsp_pkg::result_t skid_res;
  logic              pop;

  assign can_take = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= push_res;
      end
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

@@ hdl/lidar_point_stream_parser_top.sv @@
`timescale 1ns / 1ps
// A completed result is registered into the output, or into the skid entry if stalled.
// Throughput: one byte per cycle while in_ready is high; each byte updates parse state.
// in_ready drops only while the skid entry is occupied by a stalled result.
// Reset (synchronous, rst high) returns the parser to signature check with position,
// counters and point total at zero, clears halt and empties the result buffer.
// ----------------------------------------------------------------------------
// lidar_point_stream_parser_top
// Byte-stream lidar file parser emitting point coordinates and error results.
// ----------------------------------------------------------------------------
module lidar_point_stream_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [31:0] coord_x,
  output logic signed [31:0] coord_y,
  output logic signed [31:0] coord_z,
  output logic [31:0]        points_seen
);

  logic              accept;
  logic              push;
  lpsp_pkg::result_t res;
  lpsp_pkg::result_t out_res;

  assign accept = in_valid && in_ready;

  lpsp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .push      (push),
    .res       (res)
  );

  lpsp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push && accept),
    .push_res  (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign coord_x     = out_res.coord_x;
  assign coord_y     = out_res.coord_y;
  assign coord_z     = out_res.coord_z;
  assign points_seen = out_res.points_seen;

endmodule
